// File: hw/rtl/mnhrt_pkg.sv
// Shared types and codes for the mesh next-hop route table.
`default_nettype none

package mnhrt_pkg;

    // Width of one station address.
    localparam int unsigned MAC_W = 48;

    // Request operation codes.
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_LEARN  = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Response status codes.
    localparam logic [2:0] STAT_FOUND     = 3'd0;
    localparam logic [2:0] STAT_MISS      = 3'd1;
    localparam logic [2:0] STAT_ADDED     = 3'd2;
    localparam logic [2:0] STAT_UPDATED   = 3'd3;
    localparam logic [2:0] STAT_UNCHANGED = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;
    localparam logic [2:0] STAT_REMOVED   = 3'd6;

    // One table request.
    typedef struct packed {
        logic [1:0]       op;
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] via_mac;
    } t_req;

    // One table response.
    typedef struct packed {
        logic [MAC_W-1:0] next_hop_mac;
        logic             hit;
        logic [2:0]       status;
    } t_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/mesh_next_hop_route_table_top.sv
// Top level of the mesh next-hop route table: scan control, valid bits and output register.
// A new request is taken only in the idle state, once the previous request has passed
// through the scan that reads the destination memory one entry per cycle and its
// response has been loaded into the output register.
// A new request is accepted while the previous response still waits in the output register.
// Reset clears all valid bits at once, so the table is empty with no clearing pass;
// the address memories themselves are not reset.
`default_nettype none

module mesh_next_hop_route_table_top #(
    parameter int unsigned ROUTE_ENTRIES = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output      logic           o_req_ready,
    input  wire mnhrt_pkg::t_req i_req,
    output      logic           o_res_valid,
    input  wire logic           i_res_ready,
    output      mnhrt_pkg::t_rsp o_res
);

    localparam int unsigned AW = $clog2(ROUTE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(ROUTE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HOP,
        S_DECIDE,
        S_DRAIN
    } t_state;

    t_state r_state;

    // Captured request.
    mnhrt_pkg::t_req r_req;

    // Scan bookkeeping.
    logic          r_issuing;
    logic [AW-1:0] r_scan_idx;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;
    logic          r_hit;
    logic [AW-1:0] r_match_idx;
    logic          r_free_found;
    logic [AW-1:0] r_free_idx;

    // Valid bit for each table entry.
    logic [ROUTE_ENTRIES-1:0] r_valid;

    // Response waiting to be handed to the output register.
    mnhrt_pkg::t_rsp r_pend;

    // Memory ports.
    logic [mnhrt_pkg::MAC_W-1:0] rd_dest;
    logic [mnhrt_pkg::MAC_W-1:0] rd_hop;
    logic                        dest_we;
    logic                        hop_we;
    logic [AW-1:0]               wr_addr;

    // Decision results.
    mnhrt_pkg::t_rsp n_pend;
    logic            n_add;
    logic            cmp_match;

    assign o_req_ready = (r_state == S_IDLE);

    // Compare the destination read back with the request.
    assign cmp_match = r_cmp_vld && r_valid[r_cmp_idx] && (rd_dest == r_req.dest_mac);

    // Work out the response and the write-back from the scan result and the stored hop.
    always_comb begin
        n_pend   = '0;
        n_add    = 1'b0;
        dest_we  = 1'b0;
        hop_we   = 1'b0;
        wr_addr  = r_match_idx;
        n_pend.hit = r_hit;
        if (r_req.op == mnhrt_pkg::OP_LEARN) begin
            if (r_hit) begin
                if (rd_hop != r_req.via_mac) begin
                    hop_we        = (r_state == S_DECIDE);
                    n_pend.status = mnhrt_pkg::STAT_UPDATED;
                end else begin
                    n_pend.status = mnhrt_pkg::STAT_UNCHANGED;
                end
            end else if (r_req.dest_mac == r_req.via_mac) begin
                n_pend.status = mnhrt_pkg::STAT_UNCHANGED;
            end else if (r_free_found) begin
                wr_addr       = r_free_idx;
                n_add         = (r_state == S_DECIDE);
                dest_we       = n_add;
                hop_we        = n_add;
                n_pend.status = mnhrt_pkg::STAT_ADDED;
            end else begin
                n_pend.status = mnhrt_pkg::STAT_FULL;
            end
        end else if (r_req.op == mnhrt_pkg::OP_DELETE) begin
            n_pend.status = r_hit ? mnhrt_pkg::STAT_REMOVED : mnhrt_pkg::STAT_MISS;
        end else begin
            n_pend.next_hop_mac = r_hit ? rd_hop : r_req.dest_mac;
            n_pend.status       = r_hit ? mnhrt_pkg::STAT_FOUND : mnhrt_pkg::STAT_MISS;
        end
    end

    // Destination memory: read by the scan, written when an entry is added.
    mnhrt_ram #(
        .DEPTH(ROUTE_ENTRIES),
        .WIDTH(mnhrt_pkg::MAC_W)
    ) u_dest_ram (
        .i_clk  (i_clk),
        .i_we   (dest_we),
        .i_waddr(wr_addr),
        .i_wdata(r_req.dest_mac),
        .i_raddr(r_scan_idx),
        .o_rdata(rd_dest)
    );

    // Next-hop memory: read at the matching entry, written on add or update.
    mnhrt_ram #(
        .DEPTH(ROUTE_ENTRIES),
        .WIDTH(mnhrt_pkg::MAC_W)
    ) u_hop_ram (
        .i_clk  (i_clk),
        .i_we   (hop_we),
        .i_waddr(wr_addr),
        .i_wdata(r_req.via_mac),
        .i_raddr(r_match_idx),
        .o_rdata(rd_hop)
    );

    // Request payload capture and pending response register.
    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
        if (r_state == S_DECIDE) begin
            r_pend <= n_pend;
        end
    end

    // Control state, scan, valid bits and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issuing    <= 1'b0;
            r_scan_idx   <= '0;
            r_cmp_vld    <= 1'b0;
            r_cmp_idx    <= '0;
            r_hit        <= 1'b0;
            r_match_idx  <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_valid      <= '0;
            o_res_valid  <= 1'b0;
            o_res        <= '0;
        end else begin
            // The consumer takes the waiting response; the drain state reloads it itself.
            if (o_res_valid && i_res_ready && (r_state != S_DRAIN)) begin
                o_res_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state      <= S_SCAN;
                        r_issuing    <= 1'b1;
                        r_scan_idx   <= '0;
                        r_cmp_vld    <= 1'b0;
                        r_hit        <= 1'b0;
                        r_match_idx  <= '0;
                        r_free_found <= 1'b0;
                        r_free_idx   <= '0;
                    end
                end
                S_SCAN: begin
                    // Issue one destination read per cycle.
                    if (r_issuing) begin
                        if (r_scan_idx == LAST_IDX) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_scan_idx <= r_scan_idx + AW'(1);
                        end
                    end
                    r_cmp_vld <= r_issuing;
                    r_cmp_idx <= r_scan_idx;

                    // Check the entry read in the previous cycle.
                    if (r_cmp_vld) begin
                        if (cmp_match && !r_hit) begin
                            r_hit       <= 1'b1;
                            r_match_idx <= r_cmp_idx;
                        end
                        if (cmp_match && (r_req.op == mnhrt_pkg::OP_DELETE)) begin
                            r_valid[r_cmp_idx] <= 1'b0;
                        end
                        if (!r_valid[r_cmp_idx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_cmp_idx;
                        end
                        if (r_cmp_idx == LAST_IDX) begin
                            r_state <= S_HOP;
                        end
                    end
                end
                S_HOP: begin
                    // Next-hop memory is being read at the matching entry.
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (n_add) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!o_res_valid || i_res_ready) begin
                        o_res       <= r_pend;
                        o_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // An accepted request starts the scan at the first entry.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_SCAN && r_issuing && r_scan_idx == '0))
        else $error("scan did not start at entry zero");

    // A delete that hit has cleared the first matching entry by the end of the scan.
    a_delete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOP && r_req.op == mnhrt_pkg::OP_DELETE && r_hit)
            |-> !r_valid[r_match_idx])
        else $error("deleted entry still valid");

    // A new entry only ever goes into a free slot.
    a_add_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && n_add) |-> !r_valid[r_free_idx])
        else $error("add targets an occupied slot");

    // A hit always points at an entry that was valid during the scan.
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_hit && r_req.op != mnhrt_pkg::OP_DELETE)
            |-> r_valid[r_match_idx])
        else $error("hit on an invalid entry");

    // The output register is loaded only from the drain state.
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(r_state == S_DRAIN))
        else $error("response appeared outside drain");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/mnhrt_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module mnhrt_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: tb/route_table_checker.sv
// Shadow route table that predicts every response of the route table and compares it.
`default_nettype none

module route_table_checker #(
    parameter int unsigned ROUTE_ENTRIES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  wire logic            i_req_ready,
    input  wire mnhrt_pkg::t_req i_req,
    input  wire logic            i_res_valid,
    input  wire logic            i_res_ready,
    input  wire mnhrt_pkg::t_rsp i_res,
    output int unsigned          o_fail_count,
    output int unsigned          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the table.
    logic [mnhrt_pkg::MAC_W-1:0] shadow_dest [ROUTE_ENTRIES];
    logic [mnhrt_pkg::MAC_W-1:0] shadow_hop  [ROUTE_ENTRIES];
    logic                        shadow_valid[ROUTE_ENTRIES];

    // Responses predicted for accepted requests, oldest first.
    mnhrt_pkg::t_rsp route_rsp_q[$];
    int unsigned     mismatch_count = 0;

    // Apply one request to the shadow table and return the response it must produce.
    function automatic mnhrt_pkg::t_rsp apply_route_op(input mnhrt_pkg::t_req r);
        mnhrt_pkg::t_rsp rsp;
        int   idx;
        int   slot;
        int   i;
        rsp  = '0;
        idx  = -1;
        slot = -1;
        // Lowest valid match and lowest free slot.
        for (i = ROUTE_ENTRIES - 1; i >= 0; i--) begin
            if (shadow_valid[i] && shadow_dest[i] == r.dest_mac) begin
                idx = i;
            end
            if (!shadow_valid[i]) begin
                slot = i;
            end
        end
        rsp.hit = (idx >= 0);
        case (r.op)
            mnhrt_pkg::OP_LEARN: begin
                if (idx >= 0) begin
                    if (shadow_hop[idx] != r.via_mac) begin
                        shadow_hop[idx] = r.via_mac;
                        rsp.status = mnhrt_pkg::STAT_UPDATED;
                    end else begin
                        rsp.status = mnhrt_pkg::STAT_UNCHANGED;
                    end
                end else if (r.dest_mac == r.via_mac) begin
                    // The sender is a direct neighbor, so no route is stored.
                    rsp.status = mnhrt_pkg::STAT_UNCHANGED;
                end else if (slot >= 0) begin
                    shadow_dest[slot]  = r.dest_mac;
                    shadow_hop[slot]   = r.via_mac;
                    shadow_valid[slot] = 1'b1;
                    rsp.status = mnhrt_pkg::STAT_ADDED;
                end else begin
                    rsp.status = mnhrt_pkg::STAT_FULL;
                end
            end
            mnhrt_pkg::OP_DELETE: begin
                if (idx >= 0) begin
                    for (i = 0; i < ROUTE_ENTRIES; i++) begin
                        if (shadow_valid[i] && shadow_dest[i] == r.dest_mac) begin
                            shadow_valid[i] = 1'b0;
                        end
                    end
                    rsp.status = mnhrt_pkg::STAT_REMOVED;
                end else begin
                    rsp.status = mnhrt_pkg::STAT_MISS;
                end
            end
            default: begin
                // Lookup; the spare opcode behaves the same way.
                if (idx >= 0) begin
                    rsp.next_hop_mac = shadow_hop[idx];
                    rsp.status = mnhrt_pkg::STAT_FOUND;
                end else begin
                    rsp.next_hop_mac = r.dest_mac;
                    rsp.status = mnhrt_pkg::STAT_MISS;
                end
            end
        endcase
        return rsp;
    endfunction

    // Compare responses first, then predict the request taken at the same edge.
    always @(posedge i_clk) begin
        mnhrt_pkg::t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < ROUTE_ENTRIES; i++) begin
                shadow_valid[i] = 1'b0;
            end
            route_rsp_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (route_rsp_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%t: response with none outstanding: hop=%h hit=%b status=%0d",
                                 $realtime, i_res.next_hop_mac, i_res.hit, i_res.status);
                    end
                end else begin
                    want = route_rsp_q.pop_front();
                    if (i_res.next_hop_mac !== want.next_hop_mac || i_res.hit !== want.hit
                        || i_res.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%t: response mismatch: exp hop=%h hit=%b status=%0d",
                                     $realtime, want.next_hop_mac, want.hit, want.status);
                            $display("%t:                    got hop=%h hit=%b status=%0d",
                                     $realtime, i_res.next_hop_mac, i_res.hit, i_res.status);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                route_rsp_q = {route_rsp_q, apply_route_op(i_req)};
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= route_rsp_q.size();
    end

endmodule

`default_nettype wire

// File: tb/tb_mesh_next_hop_route_table_top.sv
// Testbench top for the mesh next-hop route table: stimulus, flow control and verdict.
`default_nettype none

module tb_mesh_next_hop_route_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned                 ROUTE_ENTRIES = 16;
    localparam logic [1:0]                  OP_SPARE      = 2'd3;
    localparam logic [mnhrt_pkg::MAC_W-1:0] MAC_ONES      = '1;
    localparam logic [mnhrt_pkg::MAC_W-1:0] MAC_A         = 48'h02_1A_2B_3C_4D_00;
    localparam logic [mnhrt_pkg::MAC_W-1:0] MAC_B         = 48'h06_77_88_99_AA_BB;
    localparam logic [mnhrt_pkg::MAC_W-1:0] MAC_C         = 48'h0A_C0_FF_EE_10_20;
    localparam int unsigned                 DEST_POOL     = 24;
    localparam int unsigned                 VIA_POOL      = 4;
    localparam int unsigned                 PHASE_REQS    = 500;
    localparam int unsigned                 HOLD_CYCLES   = 300;
    localparam int unsigned                 PRESSURE_REQS = 12;
    localparam int unsigned                 WDOG_LIMIT    = 3000;
    localparam int unsigned                 DRAIN_CYCLES  = ROUTE_ENTRIES + 10;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    mnhrt_pkg::t_req req       = '0;
    logic            res_valid;
    logic            res_ready = 1'b0;
    mnhrt_pkg::t_rsp res;
    int unsigned     fail_count;
    int unsigned     pending;

    // Flow control knobs (idle and stall rates in percent), shared with the response sink, and the watchdog count.
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    bit          hold_off_req = 1'b0;
    int unsigned quiet_cycles = 0;

    logic [mnhrt_pkg::MAC_W-1:0] dest_pool[DEST_POOL];
    logic [mnhrt_pkg::MAC_W-1:0] via_pool[VIA_POOL];

    mesh_next_hop_route_table_top #(
        .ROUTE_ENTRIES(ROUTE_ENTRIES)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req      (req),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    route_table_checker #(
        .ROUTE_ENTRIES(ROUTE_ENTRIES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_req       (req),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_res       (res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock.
    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [mnhrt_pkg::MAC_W-1:0] rand_mac();
        return {16'($urandom), $urandom};
    endfunction

    function automatic mnhrt_pkg::t_req mk_req(input logic [1:0] op,
                                               input logic [mnhrt_pkg::MAC_W-1:0] dest,
                                               input logic [mnhrt_pkg::MAC_W-1:0] via);
        mnhrt_pkg::t_req r;
        r.op       = op;
        r.dest_mac = dest;
        r.via_mac  = via;
        return r;
    endfunction

    // Random request drawn mostly from a small address pool, so that entries are
    // hit, updated, removed and the table runs full.
    function automatic mnhrt_pkg::t_req random_req();
        mnhrt_pkg::t_req r;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            r.op = mnhrt_pkg::OP_LOOKUP;
        end else if (pick < 70) begin
            r.op = mnhrt_pkg::OP_LEARN;
        end else if (pick < 92) begin
            r.op = mnhrt_pkg::OP_DELETE;
        end else begin
            r.op = OP_SPARE;
        end
        if ($urandom_range(99) < 85) begin
            r.dest_mac = dest_pool[$urandom_range(DEST_POOL - 1)];
        end else begin
            r.dest_mac = rand_mac();
        end
        pick = $urandom_range(99);
        if (r.op == mnhrt_pkg::OP_LEARN && pick < 15) begin
            r.via_mac = r.dest_mac;
        end else if (pick < 75) begin
            r.via_mac = via_pool[$urandom_range(VIA_POOL - 1)];
        end else begin
            r.via_mac = rand_mac();
        end
        return r;
    endfunction

    // Offer one request after an optional idle gap and wait until it is taken.
    task automatic send_req(input mnhrt_pkg::t_req r);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (idle_pct != 0 && $urandom_range(7) == 0) begin
            gap += $urandom_range(1, 25);
        end
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do begin
            @(posedge clk);
        end while (!req_ready);
    endtask

    // Response sink: random stalls, plus one long hold-off on request.
    initial begin
        int unsigned k;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                res_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    @(posedge clk);
                end
                hold_off_req = 1'b0;
            end
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves a request or response.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial begin
        int unsigned k;
        int unsigned ph;
        int unsigned phase_idle[4];
        int unsigned phase_stall[4];
        phase_idle  = '{0, 62, 0, 29};
        phase_stall = '{0, 0, 62, 29};

        dest_pool[0] = '0;
        dest_pool[1] = MAC_ONES;
        for (k = 2; k < DEST_POOL; k++) begin
            dest_pool[k] = rand_mac();
        end
        via_pool[0] = MAC_ONES;
        for (k = 1; k < VIA_POOL; k++) begin
            via_pool[k] = rand_mac();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests on an empty table.
        send_req(mk_req(mnhrt_pkg::OP_LOOKUP, '0, MAC_ONES));        // miss returns the destination
        send_req(mk_req(mnhrt_pkg::OP_DELETE, MAC_ONES, '0));        // delete of an absent route
        send_req(mk_req(mnhrt_pkg::OP_LEARN, MAC_A, MAC_A));         // direct neighbor is not stored
        send_req(mk_req(mnhrt_pkg::OP_LEARN, MAC_ONES, '0));         // added in the first slot
        send_req(mk_req(mnhrt_pkg::OP_LEARN, '0, MAC_ONES));         // added in the second slot
        send_req(mk_req(mnhrt_pkg::OP_LEARN, MAC_ONES, '0));         // same hop leaves it unchanged
        send_req(mk_req(mnhrt_pkg::OP_LEARN, MAC_ONES, MAC_B));      // new hop updates the entry
        send_req(mk_req(mnhrt_pkg::OP_LOOKUP, MAC_ONES, '0));        // found
        send_req(mk_req(OP_SPARE, '0, '0));                          // spare opcode acts as lookup
        send_req(mk_req(mnhrt_pkg::OP_DELETE, MAC_ONES, MAC_ONES));  // removed, first slot free
        send_req(mk_req(mnhrt_pkg::OP_LOOKUP, MAC_ONES, '0));        // miss after removal

        // Fill the table; the first add must reuse the lowest free slot.
        for (k = 0; k < ROUTE_ENTRIES - 1; k++) begin
            send_req(mk_req(mnhrt_pkg::OP_LEARN, MAC_A ^ 48'(k + 1), MAC_B));
        end
        send_req(mk_req(mnhrt_pkg::OP_LEARN, MAC_C, MAC_B));  // store full, dropped
        send_req(mk_req(mnhrt_pkg::OP_LEARN, '0, MAC_C));     // update still works when full
        send_req(mk_req(mnhrt_pkg::OP_DELETE, '0, '0));       // frees the second slot
        send_req(mk_req(mnhrt_pkg::OP_LEARN, MAC_C, MAC_B));  // lands in the freed slot

        // Hold the response side off while requests keep coming, so the block backs up.
        hold_off_req = 1'b1;
        for (k = 0; k < PRESSURE_REQS; k++) begin
            send_req(random_req());
        end

        // Random requests under several idle and stall mixes.
        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (k = 0; k < PHASE_REQS; k++) begin
                send_req(random_req());
            end
        end
        req_valid <= 1'b0;

        // Drain outstanding responses, then allow for anything still in flight.
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/mnhrt_pkg.sv
hw/rtl/mnhrt_ram.sv
hw/rtl/mesh_next_hop_route_table_top.sv
tb/route_table_checker.sv
tb/tb_mesh_next_hop_route_table_top.sv
